### hw/rtl/three_voice_sound_generator_macros.svh
// Assertion macros shared by the checker of the sound generator.
// Depends on nothing; include guarded.
`ifndef THREE_VOICE_SOUND_GENERATOR_MACROS_SVH
`define THREE_VOICE_SOUND_GENERATOR_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define TVSG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TVSG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

### hw/rtl/tvsg_pkg.sv
// Package of the three-voice sound generator: types, constants, tables.
// Used by the divider, datapath, controller and top level; depends on nothing.
package tvsg_pkg;
   localparam logic [2:0] CsrToneDiv = 3'd0;
   localparam logic [2:0] CsrEnvDiv  = 3'd1;
   localparam logic [2:0] CsrGain    = 3'd2;
   localparam logic [7:0] MixerReset = 8'h3F;
   localparam logic [8:0] GainReset  = 9'd205;
   localparam logic [11:0] SampleMax = 12'd4095;

   // Which divided value a division result is written to.
   typedef enum logic [2:0] {
      DIV_TONE0, DIV_TONE1, DIV_TONE2, DIV_NOISE, DIV_ENV
   } div_sel_type;

   typedef struct packed {
      logic        write;      // store register byte
      logic        div_start;  // start a division
      div_sel_type div_sel;
      logic        env_check;  // load envelope period, restart if settings changed
      logic        tick;       // advance generators and clear mix sum
      logic        mix_step;   // add one channel to the sum
      logic [1:0]  mix_ch;
      logic        scale;      // saturate product into the sample
   } cmd_type;

   typedef struct packed {
      logic div_busy;
   } status_type;

   function automatic logic [10:0] vol_level(input logic [3:0] lvl);
      logic [10:0] v;
      unique case (lvl)
         4'd0: v = 11'd0;     4'd1: v = 11'd80;    4'd2: v = 11'd100;
         4'd3: v = 11'd130;   4'd4: v = 11'd160;   4'd5: v = 11'd200;
         4'd6: v = 11'd250;   4'd7: v = 11'd300;   4'd8: v = 11'd370;
         4'd9: v = 11'd450;   4'd10: v = 11'd550;  4'd11: v = 11'd680;
         4'd12: v = 11'd850;  4'd13: v = 11'd1050; 4'd14: v = 11'd1300;
         default: v = 11'd1600;
      endcase
      return v;
   endfunction
endpackage

### hw/rtl/tvsg_divider.sv
// Restoring divider, one quotient bit per cycle, result floored at one.
// Depends on tvsg_pkg.
module tvsg_divider import tvsg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [8:0]  divisor,
   output logic        busy,
   output logic [15:0] quotient
);
   logic [15:0] q_ff, q_in;
   logic [16:0] rem_ff, rem_in;
   logic [8:0]  dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [16:0] trial;

   always_comb begin
      q_in = q_ff; rem_in = rem_ff; dvs_in = dvs_ff;
      cnt_in = cnt_ff; busy_in = busy_ff;
      trial = {rem_ff[15:0], q_ff[15]};
      if (start) begin
         q_in = dividend; rem_in = '0;
         dvs_in = (divisor == 9'd0) ? 9'd1 : divisor;
         cnt_in = 5'd16; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {8'd0, dvs_ff}) begin
            rem_in = trial - {8'd0, dvs_ff};
            q_in = {q_ff[14:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in = {q_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; cnt_ff <= cnt_in;
      end
      q_ff <= q_in; rem_ff <= rem_in; dvs_ff <= dvs_in;
   end

   assign busy = busy_ff;
   assign quotient = (q_ff == 16'd0) ? 16'd1 : q_ff;
endmodule

### hw/rtl/tvsg_datapath.sv
// Datapath: register file, generators, divider, mixer and gain.
// Depends on tvsg_pkg and tvsg_divider.
module tvsg_datapath import tvsg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [3:0]  wr_address,
   input  logic [7:0]  wr_data,
   input  logic [4:0]  tone_div,
   input  logic [8:0]  env_div,
   input  logic [8:0]  gain,
   output logic [11:0] sample
);
   logic [7:0]  regs_ff [16];
   logic [11:0] tcnt_ff [3];
   logic [11:0] tper_ff [3];
   logic [2:0]  tlvl_ff;
   logic [16:0] nshift_ff;
   logic [4:0]  ncnt_ff, nper_ff;
   logic        nlvl_ff;
   logic [15:0] ecnt_ff, eper_ff;
   logic [3:0]  estep_ff;
   logic        erise_ff, efrozen_ff;
   logic        lvalid_ff;
   logic [15:0] lper_ff;
   logic [3:0]  lshape_ff;
   logic [12:0] sum_ff;
   logic [21:0] prod_ff;
   logic [11:0] sample_ff;

   logic [15:0] dividend, quotient;
   logic [8:0]  divisor;
   logic        div_busy;

   always_comb begin
      unique case (cmd.div_sel)
         DIV_TONE0: dividend = {4'd0, regs_ff[1][3:0], regs_ff[0]};
         DIV_TONE1: dividend = {4'd0, regs_ff[3][3:0], regs_ff[2]};
         DIV_TONE2: dividend = {4'd0, regs_ff[5][3:0], regs_ff[4]};
         DIV_NOISE: dividend = {11'd0, regs_ff[6][4:0]};
         default:   dividend = {regs_ff[12], regs_ff[11]};
      endcase
      divisor = (cmd.div_sel == DIV_ENV) ? env_div : {4'd0, tone_div};
   end

   tvsg_divider u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start), .dividend(dividend),
      .divisor(divisor), .busy(div_busy), .quotient(quotient)
   );
   assign status.div_busy = div_busy;

   logic [15:0] env_period;
   logic [3:0]  shape;
   assign env_period = {regs_ff[12], regs_ff[11]};
   assign shape = regs_ff[13][3:0];

   // Envelope step on reaching its period.
   logic [3:0] estep_nx;
   logic       erise_nx, efrozen_nx;
   always_comb begin
      estep_nx = estep_ff; erise_nx = erise_ff; efrozen_nx = efrozen_ff;
      if (erise_ff ? (estep_ff != 4'd15) : (estep_ff != 4'd0)) begin
         estep_nx = erise_ff ? estep_ff + 4'd1 : estep_ff - 4'd1;
      end else if (!shape[3]) begin
         estep_nx = 4'd0; efrozen_nx = 1'b1;
      end else if (shape[0]) begin
         if (shape[1]) estep_nx = 4'd15 - estep_ff;
         efrozen_nx = 1'b1;
      end else if (shape[1]) begin
         erise_nx = !erise_ff;
      end else begin
         estep_nx = erise_ff ? 4'd0 : 4'd15;
      end
   end

   logic [11:0] tinc [3];
   logic [4:0]  ninc;
   logic [15:0] einc;
   logic        nfb;
   always_comb begin
      for (int c = 0; c < 3; c++) tinc[c] = tcnt_ff[c] + 12'd1;
      ninc = ncnt_ff + 5'd1;
      einc = ecnt_ff + 16'd1;
      nfb = nshift_ff[0] ^ nshift_ff[3];
   end

   // Per-channel contribution for the mix step.
   logic [7:0]  vr;
   logic [3:0]  lvl;
   logic        t_on, n_on;
   always_comb begin
      vr = regs_ff[{2'b10, cmd.mix_ch}];
      lvl = vr[4] ? estep_ff : vr[3:0];
      t_on = regs_ff[7][cmd.mix_ch] | tlvl_ff[cmd.mix_ch];
      n_on = regs_ff[7][{1'b0, cmd.mix_ch} + 3'd3] | nlvl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) regs_ff[i] <= (i == 7) ? MixerReset : 8'd0;
         for (int c = 0; c < 3; c++) begin
            tcnt_ff[c] <= 12'd0; tper_ff[c] <= 12'd1;
         end
         tlvl_ff <= 3'b111;
         nshift_ff <= 17'd1; ncnt_ff <= 5'd0; nper_ff <= 5'd1; nlvl_ff <= 1'b1;
         ecnt_ff <= 16'd0; eper_ff <= 16'd1; estep_ff <= 4'd15;
         erise_ff <= 1'b0; efrozen_ff <= 1'b0; lvalid_ff <= 1'b0;
         lper_ff <= 16'd0; lshape_ff <= 4'd0;
         sample_ff <= 12'd0;
      end else begin
         if (cmd.write) regs_ff[wr_address] <= wr_data;
         if (cmd.env_check) begin
            eper_ff <= quotient;
            if (!lvalid_ff || env_period != lper_ff || shape != lshape_ff) begin
               ecnt_ff <= 16'd0; efrozen_ff <= 1'b0;
               erise_ff <= shape[2]; estep_ff <= shape[2] ? 4'd0 : 4'd15;
               lvalid_ff <= 1'b1; lper_ff <= env_period; lshape_ff <= shape;
            end
         end
         if (cmd.div_start && cmd.div_sel != DIV_TONE0) begin
            // result of the previous division is ready when the next starts
            unique case (cmd.div_sel)
               DIV_TONE1: tper_ff[0] <= quotient[11:0];
               DIV_TONE2: tper_ff[1] <= quotient[11:0];
               DIV_NOISE: tper_ff[2] <= quotient[11:0];
               default:   nper_ff <= quotient[4:0];
            endcase
         end
         if (cmd.tick) begin
            if (ninc >= nper_ff) begin
               ncnt_ff <= 5'd0;
               nshift_ff <= {nfb, nshift_ff[16:1]};
               nlvl_ff <= nshift_ff[1];
            end else ncnt_ff <= ninc;
            for (int c = 0; c < 3; c++) begin
               if (tinc[c] >= tper_ff[c]) begin
                  tcnt_ff[c] <= 12'd0; tlvl_ff[c] <= !tlvl_ff[c];
               end else tcnt_ff[c] <= tinc[c];
            end
            if (!efrozen_ff) begin
               if (einc >= eper_ff) begin
                  ecnt_ff <= 16'd0;
                  estep_ff <= estep_nx; erise_ff <= erise_nx; efrozen_ff <= efrozen_nx;
               end else ecnt_ff <= einc;
            end
         end
         if (cmd.scale) sample_ff <= (prod_ff[21:8] > {2'd0, SampleMax}) ? SampleMax
                                                                        : prod_ff[19:8];
      end
      if (cmd.tick) sum_ff <= 13'd0;
      else if (cmd.mix_step && t_on && n_on) sum_ff <= sum_ff + {2'd0, vol_level(lvl)};
      prod_ff <= sum_ff * gain;
   end

   assign sample = sample_ff;
endmodule

### hw/rtl/tvsg_controller.sv
// Controller: sequences register writes, divisions, ticks and mixing.
// Depends on tvsg_pkg.
module tvsg_controller import tvsg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_action,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_DSTART, S_DWAIT, S_ENV, S_MIX, S_PROD, S_SCALE, S_OUT
   } state_type;

   state_type   state_ff, state_in;
   div_sel_type sel_ff, sel_in;
   logic [1:0]  ch_ff, ch_in;
   logic        rsp_ff, rsp_in;

   always_comb begin
      state_in = state_ff; sel_in = sel_ff; ch_in = ch_ff;
      rsp_in = rsp_ff;
      cmd = '0;
      cmd.div_sel = sel_ff; cmd.mix_ch = ch_ff;
      if (rsp_ff && rsp_ready) rsp_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               if (req_action) begin
                  cmd.write = 1'b1; sel_in = DIV_TONE0; state_in = S_DSTART;
               end else begin
                  cmd.tick = 1'b1; ch_in = 2'd0; state_in = S_MIX;
               end
            end
         end
         S_DSTART: begin
            cmd.div_start = 1'b1; state_in = S_DWAIT;
         end
         S_DWAIT: begin
            if (!status.div_busy) begin
               if (sel_ff == DIV_ENV) state_in = S_ENV;
               else begin
                  sel_in = div_sel_type'(sel_ff + 3'd1); state_in = S_DSTART;
               end
            end
         end
         S_ENV: begin
            cmd.env_check = 1'b1; state_in = S_IDLE;
         end
         S_MIX: begin
            cmd.mix_step = 1'b1;
            if (ch_ff == 2'd2) state_in = S_PROD;
            ch_in = ch_ff + 2'd1;
         end
         S_PROD: state_in = S_SCALE;
         S_SCALE: begin
            // The output register is only overwritten once its item has gone.
            if (!rsp_ff || rsp_ready) begin
               cmd.scale = 1'b1; state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_ff || rsp_ready) begin
               rsp_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; sel_ff <= DIV_TONE0; ch_ff <= 2'd0;
         rsp_ff <= 1'b0;
      end else begin
         state_ff <= state_in; sel_ff <= sel_in; ch_ff <= ch_in;
         rsp_ff <= rsp_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_ff;
endmodule

### hw/rtl/three_voice_sound_generator.sv
// Three-voice sound generator. A sample tick passes through the mix of three channels, the
// product, saturate and output steps; the sample is offered as the input reopens, provided
// the previous sample has left; a waiting sample holds the saturate step.
// A register write runs five serial divisions (a start, then a wait for the result) in the
// shared divider, then the envelope check. One item at a time. Reset (synchronous, active
// high) restores the register file and generator state.
module three_voice_sound_generator import tvsg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [3:0]  req_reg_address,
   input  logic [7:0]  req_reg_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_sample,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_data
);
   // Configuration registers are always writable.
   logic [4:0] tone_div_ff;
   logic [8:0] env_div_ff, gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_div_ff <= 5'd1; env_div_ff <= 9'd1; gain_ff <= GainReset;
      end else if (csr_valid) begin
         unique case ({1'b0, csr_index})
            CsrToneDiv: tone_div_ff <= csr_data[4:0];
            CsrEnvDiv:  env_div_ff  <= csr_data;
            CsrGain:    gain_ff     <= csr_data;
            default: ;
         endcase
      end
   end
   assign csr_ready = 1'b1;

   cmd_type    cmd;
   status_type status;

   tvsg_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_action(req_action), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .status(status), .cmd(cmd)
   );

   // The write address and data are taken in the acceptance cycle itself.
   tvsg_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .wr_address(req_reg_address), .wr_data(req_reg_data),
      .tone_div(tone_div_ff), .env_div(env_div_ff), .gain(gain_ff),
      .sample(rsp_sample)
   );
endmodule

### hw/rtl/tvsg_checker.sv
// Port-level checker for the sound generator, bound to the top level.
// Depends on the assertion macro header.
`include "three_voice_sound_generator_macros.svh"
module tvsg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_action,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [11:0] rsp_sample
);
   // A pending result holds its sample.
   `TVSG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sample))
   // A write item keeps the input closed in the following cycle.
   `TVSG_ASSERT_NEXT(a_write_silent, clock, reset, req_valid && req_ready && req_action, !req_ready)
   // No item is taken in the cycle right after another.
   `TVSG_ASSERT_NEXT(a_one_at_time, clock, reset, req_valid && req_ready, !req_ready)
endmodule

bind three_voice_sound_generator tvsg_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_action(req_action), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_sample(rsp_sample)
);
